FILE: hdl/addressed_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the addressed frame receiver
// Shared property forms; every use sits in a module with i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef ADDRESSED_FRAME_RECEIVER_ASSERT_SVH
`define ADDRESSED_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define AFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define AFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define AFR_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// Types and constants shared by the addressed frame receiver.
// ----------------------------------------------------------------------------
package afr_pkg;

    localparam int BYTE_W = 8;

    typedef logic [BYTE_W-1:0] t_byte;

    localparam t_byte BROADCAST_ADDR  = 8'hFF;
    localparam t_byte NODE_ADDR_RESET = 8'h01;
    localparam t_byte SUM_GOOD        = 8'hFF;

    // result kind codes
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef struct packed {
        logic  kind;
        t_byte payload_byte;
        t_byte payload_index;
        t_byte dest_address;
        t_byte source_address;
        t_byte sequence_id;
        t_byte command_code;
        t_byte channel_number;
        t_byte payload_size;
        logic  frame_ok;
    } t_result;

endpackage

FILE: hdl/afr_if.sv
// ----------------------------------------------------------------------------
// afr_in_if / afr_out_if
// Valid/ready channels for received bytes and for receiver results.
// ----------------------------------------------------------------------------
interface afr_in_if
    import afr_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte rx_byte;
    logic  address_mark;

    modport source (output valid, output rx_byte, output address_mark, input ready);
    modport sink   (input valid, input rx_byte, input address_mark, output ready);
endinterface

interface afr_out_if
    import afr_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  kind;
    t_byte payload_byte;
    t_byte payload_index;
    t_byte dest_address;
    t_byte source_address;
    t_byte sequence_id;
    t_byte command_code;
    t_byte channel_number;
    t_byte payload_size;
    logic  frame_ok;

    modport source (
        output valid, output kind, output payload_byte, output payload_index,
        output dest_address, output source_address, output sequence_id,
        output command_code, output channel_number, output payload_size,
        output frame_ok, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input payload_index,
        input dest_address, input source_address, input sequence_id,
        input command_code, input channel_number, input payload_size,
        input frame_ok, output ready
    );
endinterface

FILE: hdl/addressed_frame_receiver.sv
// ----------------------------------------------------------------------------
// addressed_frame_receiver
// Address-mark framed byte receiver with 8-bit checksum check.
// ----------------------------------------------------------------------------
// One received byte per transfer, one transfer per cycle while the result
// buffer has room. The phase machine acts on a byte in the cycle of its
// transfer; the payload or frame-end result it forms is registered on that
// edge in the output register or, while the sink stalls with that one full,
// in a second result register, so i_in.ready drops only when both are full
// and comes straight from a flop. Idle bytes that are not marked, or are
// marked with another address than node_address or 0xFF, are dropped
// silently. Inside a frame the mark bit is ignored. A frame is good when the
// wrapping sum of every byte, destination through checksum, is 0xFF. Write
// node_address (reset 0x01) only while no frame is in flight.
// ----------------------------------------------------------------------------
module addressed_frame_receiver
    import afr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  t_byte     i_cfg_wdata,
    afr_in_if.sink    i_in,
    afr_out_if.source o_out
);

    logic    accept;
    logic    room;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // ready is the buffer's free-slot flag, independent of phase
    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    afr_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (accept),
        .i_rx_byte      (i_in.rx_byte),
        .i_address_mark (i_in.address_mark),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    afr_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (out_res)
    );

    assign o_out.kind           = out_res.kind;
    assign o_out.payload_byte   = out_res.payload_byte;
    assign o_out.payload_index  = out_res.payload_index;
    assign o_out.dest_address   = out_res.dest_address;
    assign o_out.source_address = out_res.source_address;
    assign o_out.sequence_id    = out_res.sequence_id;
    assign o_out.command_code   = out_res.command_code;
    assign o_out.channel_number = out_res.channel_number;
    assign o_out.payload_size   = out_res.payload_size;
    assign o_out.frame_ok       = out_res.frame_ok;

endmodule

FILE: hdl/afr_parser.sv
// ----------------------------------------------------------------------------
// afr_parser
// Frame phase machine: address match, header capture, running sum, payload
// count; forms one result per payload or checksum byte.
// ----------------------------------------------------------------------------
module afr_parser
    import afr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  t_byte   i_cfg_wdata,
    input  logic    i_accept,
    input  t_byte   i_rx_byte,
    input  logic    i_address_mark,
    output logic    o_res_valid,
    output t_result o_res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SRC,
        PH_SEQ,
        PH_CMD,
        PH_CHAN,
        PH_SIZE,
        PH_PAYLOAD,
        PH_CHECK
    } t_phase;

    t_phase r_phase, n_phase;
    t_byte  r_node_addr;
    t_byte  r_sum, n_sum;
    t_byte  r_count, n_count;
    t_byte  r_dest, r_src, r_seq, r_cmd, r_chan, r_size;
    t_byte  sum_plus;
    t_byte  count_plus;
    logic   addr_hit;

    assign sum_plus   = r_sum + i_rx_byte;
    assign count_plus = r_count + 8'd1;
    assign addr_hit   = i_address_mark &&
                        (i_rx_byte == r_node_addr || i_rx_byte == BROADCAST_ADDR);

    always_comb begin
        n_phase = r_phase;
        n_sum   = sum_plus;
        n_count = r_count;
        case (r_phase)
            PH_IDLE: begin
                n_sum = r_sum;
                if (addr_hit) begin
                    n_sum   = i_rx_byte;
                    n_phase = PH_SRC;
                end
            end
            PH_SRC:  n_phase = PH_SEQ;
            PH_SEQ:  n_phase = PH_CMD;
            PH_CMD:  n_phase = PH_CHAN;
            PH_CHAN: n_phase = PH_SIZE;
            PH_SIZE: begin
                n_count = '0;
                n_phase = (i_rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_count = count_plus;
                if (count_plus == r_size) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: n_phase = PH_IDLE;
            default:  n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_node_addr <= NODE_ADDR_RESET;
            r_sum       <= '0;
            r_count     <= '0;
            r_dest      <= '0;
            r_src       <= '0;
            r_seq       <= '0;
            r_cmd       <= '0;
            r_chan      <= '0;
            r_size      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_node_addr <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_sum   <= n_sum;
                r_count <= n_count;
                case (r_phase)
                    PH_IDLE: if (addr_hit) r_dest <= i_rx_byte;
                    PH_SRC:  r_src  <= i_rx_byte;
                    PH_SEQ:  r_seq  <= i_rx_byte;
                    PH_CMD:  r_cmd  <= i_rx_byte;
                    PH_CHAN: r_chan <= i_rx_byte;
                    PH_SIZE: r_size <= i_rx_byte;
                    default: ;
                endcase
            end
        end
    end

    // header fields are stable for the whole payload and checksum
    always_comb begin
        o_res_valid          = i_accept && (r_phase == PH_PAYLOAD || r_phase == PH_CHECK);
        o_res.kind           = (r_phase == PH_CHECK) ? KIND_FRAME_END : KIND_PAYLOAD;
        o_res.payload_byte   = (r_phase == PH_CHECK) ? '0 : i_rx_byte;
        o_res.payload_index  = (r_phase == PH_CHECK) ? '0 : r_count;
        o_res.dest_address   = r_dest;
        o_res.source_address = r_src;
        o_res.sequence_id    = r_seq;
        o_res.command_code   = r_cmd;
        o_res.channel_number = r_chan;
        o_res.payload_size   = r_size;
        o_res.frame_ok       = (r_phase == PH_CHECK) && (sum_plus == SUM_GOOD);
    end

endmodule

FILE: hdl/afr_skid.sv
// ----------------------------------------------------------------------------
// afr_skid
// Two-entry result buffer; upstream ready comes straight from a flop.
// ----------------------------------------------------------------------------
module afr_skid
    import afr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_main_v, r_skid_v;
    t_result r_main, r_skid;
    logic    pop;

    assign pop     = r_main_v && i_ready;
    assign o_room  = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_res   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop) begin
            if (r_skid_v) begin
                r_main   <= r_skid;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_push;
                r_main   <= i_res;
            end
        end else if (!r_main_v) begin
            r_main_v <= i_push;
            r_main   <= i_res;
        end else if (i_push) begin
            r_skid   <= i_res;
            r_skid_v <= 1'b1;
        end
    end

endmodule

FILE: hdl/afr_checker.sv
// ----------------------------------------------------------------------------
// afr_checker
// Port-level checks on the receiver's result channel.
// ----------------------------------------------------------------------------
`include "addressed_frame_receiver_assert.svh"

module afr_checker
    import afr_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input logic  i_kind,
    input t_byte i_payload_byte,
    input t_byte i_payload_index,
    input t_byte i_payload_size,
    input logic  i_frame_ok
);

    `AFR_ASSERT_ALWAYS(a_no_result_after_reset, !i_rst_n, !i_out_valid, "result valid right after reset")
    `AFR_ASSERT_NEXT(a_result_held, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `AFR_ASSERT_NOW(a_end_fields_zero, i_out_valid && i_kind == KIND_FRAME_END, i_payload_byte == '0 && i_payload_index == '0, "frame end carries payload data")
    `AFR_ASSERT_NOW(a_payload_no_ok, i_out_valid && i_kind == KIND_PAYLOAD, !i_frame_ok, "payload result flags frame ok")
    `AFR_ASSERT_NOW(a_index_in_range, i_out_valid && i_kind == KIND_PAYLOAD, i_payload_index < i_payload_size, "payload index beyond announced size")

endmodule

bind addressed_frame_receiver afr_checker u_afr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_kind          (o_out.kind),
    .i_payload_byte  (o_out.payload_byte),
    .i_payload_index (o_out.payload_index),
    .i_payload_size  (o_out.payload_size),
    .i_frame_ok      (o_out.frame_ok)
);
